@@ hdl/record_stack_with_search_defines.svh @@
// Assertion macros shared by the record stack modules.
`ifndef RECORD_STACK_WITH_SEARCH_DEFINES_SVH
`define RECORD_STACK_WITH_SEARCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RSW_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RSW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/rsw_pkg.sv @@
// Types, codes and helper functions shared by the record stack modules.
package rsw_pkg;

   localparam int STACK_DEPTH_DEF = 64;

   typedef enum logic [2:0] {
      ACT_PUSH  = 3'd0,
      ACT_POP   = 3'd1,
      ACT_PEEK  = 3'd2,
      ACT_COUNT = 3'd3,
      ACT_FIND  = 3'd4,
      ACT_CLEAR = 3'd5
   } action_type;

   typedef enum logic [1:0] {
      MODE_ID   = 2'd0,
      MODE_KIND = 2'd1,
      MODE_RES  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_EMPTY = 2'd1,
      STS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_PEEK,
      S_SCAN,
      S_DRAIN,
      S_DONE
   } state_type;

   // One stored record, 64 bits, identifier in the low bits.
   typedef struct packed {
      logic        sound_boost;
      logic [7:0]  loudness;
      logic [9:0]  rate;
      logic [2:0]  kind;
      logic [12:0] height;
      logic [12:0] width;
      logic [15:0] id;
   } rec_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic scan_read;
      logic peek_take;
      logic load_rsp;
   } ctl_cmd_type;

   typedef struct packed {
      logic empty;
      logic peek;
      logic search;
      logic scan_last;
   } dp_status_type;

   function automatic logic rec_match(rec_type entry, logic [1:0] mode, rec_type key);
      logic hit;
      hit = 1'b0;
      case (mode_type'(mode))
         MODE_ID:   hit = (entry.id == key.id);
         MODE_KIND: hit = (entry.kind == key.kind);
         MODE_RES:  hit = (entry.width == key.width) && (entry.height == key.height);
         default:   hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

@@ hdl/rsw_ctrl.sv @@
// Sequencing state machine for the record stack.
module rsw_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rsw_pkg::dp_status_type dp_status,
   output rsw_pkg::ctl_cmd_type   cmd
);
   import rsw_pkg::*;
   `include "record_stack_with_search_defines.svh"

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (dp_status.empty)       state_in = S_DONE;
            else if (dp_status.peek)   state_in = S_PEEK;
            else if (dp_status.search) state_in = S_SCAN;
            else                       state_in = S_DONE;
         end
         S_PEEK: begin
            state_in = S_DONE;
         end
         S_SCAN: begin
            if (dp_status.scan_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_EXEC: begin
            cmd.execute = 1'b1;
         end
         S_PEEK: begin
            cmd.peek_take = 1'b1;
         end
         S_SCAN: begin
            cmd.scan_read = 1'b1;
         end
         S_DONE: begin
            cmd.load_rsp = rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp)   rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `RSW_ASSERT_NEXT(a_accept_exec, clock, reset, req_valid && req_ready,
      state_ff == S_EXEC, "accepted beat did not move to execute")
   `RSW_ASSERT_NEXT(a_load_valid, clock, reset, cmd.load_rsp,
      rsp_valid_ff, "loaded result not presented")
   `RSW_ASSERT_NEXT(a_done_hold, clock, reset,
      state_ff == S_DONE && rsp_valid_ff && !rsp_ready,
      state_ff == S_DONE, "result overwritten while output held")

endmodule

@@ hdl/rsw_dp.sv @@
// Datapath of the record stack: record memory, fill level, search and result registers.
module rsw_dp #(
   parameter int STACK_DEPTH = rsw_pkg::STACK_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  rsw_pkg::ctl_cmd_type    cmd,
   output rsw_pkg::dp_status_type  dp_status,
   input  logic [2:0]             req_action,
   input  logic [1:0]             req_match_mode,
   input  logic [15:0]            req_dev_id,
   input  logic [12:0]            req_dev_width,
   input  logic [12:0]            req_dev_height,
   input  logic [2:0]             req_dev_kind,
   input  logic [9:0]             req_refresh_rate,
   input  logic [7:0]             req_loudness,
   input  logic                   req_sound_boost,
   output logic [1:0]             rsp_status,
   output logic [6:0]             rsp_match_count,
   output logic                   rsp_found,
   output logic [6:0]             rsp_position,
   output logic [15:0]            rsp_top_id,
   output logic [12:0]            rsp_top_width,
   output logic [12:0]            rsp_top_height,
   output logic [2:0]             rsp_top_kind,
   output logic [9:0]             rsp_top_rate,
   output logic [7:0]             rsp_top_loudness,
   output logic                   rsp_top_sound_boost
);
   import rsw_pkg::*;
   `include "record_stack_with_search_defines.svh"

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int FW = $clog2(STACK_DEPTH + 1);

   rec_type    mem [STACK_DEPTH];

   logic [2:0]    act_ff;
   logic [1:0]    mode_ff;
   rec_type       key_ff;
   logic [FW-1:0] fill_ff, fill_in;
   logic [AW-1:0] ptr_ff;
   rec_type       rd_data_ff;
   logic          rd_vld_ff;
   status_type    res_status_ff;
   logic [FW-1:0] res_count_ff;
   logic          res_found_ff;
   logic [FW-1:0] res_pos_ff;
   logic [FW-1:0] cmp_pos_ff;
   rec_type       res_top_ff;

   logic [1:0]    rsp_status_ff;
   logic [6:0]    rsp_count_ff;
   logic          rsp_found_ff;
   logic [6:0]    rsp_pos_ff;
   rec_type       rsp_top_ff;

   logic          empty, full, wr_en, hit;
   logic [FW-1:0] fill_m1;
   logic [AW-1:0] top_addr, rd_addr;
   status_type    exec_status;
   rec_type       req_rec;

   assign req_rec = '{sound_boost: req_sound_boost, loudness: req_loudness,
                      rate: req_refresh_rate, kind: req_dev_kind,
                      height: req_dev_height, width: req_dev_width, id: req_dev_id};

   assign empty    = (fill_ff == '0);
   assign full     = (fill_ff == FW'(STACK_DEPTH));
   assign fill_m1  = fill_ff - FW'(1);
   assign top_addr = fill_m1[AW-1:0];
   assign rd_addr  = cmd.scan_read ? ptr_ff : top_addr;
   assign hit      = rec_match(rd_data_ff, mode_ff, key_ff);

   assign dp_status.empty     = empty;
   assign dp_status.peek      = (act_ff == ACT_PEEK);
   assign dp_status.search    = (act_ff == ACT_COUNT) || (act_ff == ACT_FIND);
   assign dp_status.scan_last = (ptr_ff == '0);

   always_comb begin
      exec_status = STS_OK;
      fill_in     = fill_ff;
      wr_en       = 1'b0;
      case (action_type'(act_ff))
         ACT_PUSH: begin
            if (full) begin
               exec_status = STS_FULL;
            end else begin
               wr_en   = cmd.execute;
               fill_in = fill_ff + FW'(1);
            end
         end
         ACT_POP: begin
            if (empty) exec_status = STS_EMPTY;
            else       fill_in     = fill_m1;
         end
         ACT_PEEK, ACT_COUNT, ACT_FIND: begin
            if (empty) exec_status = STS_EMPTY;
         end
         ACT_CLEAR: begin
            fill_in = '0;
         end
         default: begin
            exec_status = STS_OK;
         end
      endcase
   end

   // Single write port; the read port runs every cycle and its data is registered.
   always_ff @(posedge clock) begin
      if (wr_en) mem[fill_ff[AW-1:0]] <= key_ff;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (cmd.execute) fill_ff <= fill_in;
         rd_vld_ff <= cmd.scan_read;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff  <= req_action;
         mode_ff <= req_match_mode;
         key_ff  <= req_rec;
      end
      if (cmd.execute) begin
         res_status_ff <= exec_status;
         res_count_ff  <= '0;
         res_found_ff  <= 1'b0;
         res_pos_ff    <= '0;
         cmp_pos_ff    <= FW'(1);
         ptr_ff        <= top_addr;
         res_top_ff    <= '0;
      end else begin
         if (cmd.scan_read) ptr_ff <= ptr_ff - AW'(1);
         // The walk runs from the top down, so the first hit gives the position.
         if (rd_vld_ff) begin
            cmp_pos_ff <= cmp_pos_ff + FW'(1);
            if (hit) begin
               res_count_ff <= res_count_ff + FW'(1);
               if (!res_found_ff) begin
                  res_found_ff <= 1'b1;
                  res_pos_ff   <= cmp_pos_ff;
               end
            end
         end
         if (cmd.peek_take) res_top_ff <= rd_data_ff;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_count_ff  <= (act_ff == ACT_COUNT) ? 7'(res_count_ff) : 7'd0;
         rsp_found_ff  <= (act_ff == ACT_FIND) && res_found_ff;
         rsp_pos_ff    <= (act_ff == ACT_FIND) ? 7'(res_pos_ff) : 7'd0;
         rsp_top_ff    <= res_top_ff;
      end
   end

   assign rsp_status          = rsp_status_ff;
   assign rsp_match_count     = rsp_count_ff;
   assign rsp_found           = rsp_found_ff;
   assign rsp_position        = rsp_pos_ff;
   assign rsp_top_id          = rsp_top_ff.id;
   assign rsp_top_width       = rsp_top_ff.width;
   assign rsp_top_height      = rsp_top_ff.height;
   assign rsp_top_kind        = rsp_top_ff.kind;
   assign rsp_top_rate        = rsp_top_ff.rate;
   assign rsp_top_loudness    = rsp_top_ff.loudness;
   assign rsp_top_sound_boost = rsp_top_ff.sound_boost;

   `RSW_ASSERT_SAME(a_fill_bound, clock, reset, 1'b1,
      fill_ff <= FW'(STACK_DEPTH), "fill level beyond stack depth")
   `RSW_ASSERT_NEXT(a_push_grows, clock, reset, wr_en,
      fill_ff == $past(fill_ff) + FW'(1), "push did not raise the fill level")
   `RSW_ASSERT_NEXT(a_first_hit, clock, reset, rd_vld_ff && hit && !res_found_ff,
      res_found_ff && res_pos_ff == $past(cmp_pos_ff), "first match position lost")

endmodule

@@ hdl/record_stack_with_search.sv @@
// Push, pop, clear and unused actions go through the execute and done states; peek
// adds a peek state between them. Count and find walk the stored records one per
// cycle through the memory read port, top first, in a scan state and then a drain
// state. On an empty stack, peek, count and find go straight from execute to done.
// A new beat is taken the cycle after the result enters the output register.
// Reset empties the stack at once; the record memory itself is not cleared.
module record_stack_with_search #(
   parameter int STACK_DEPTH = rsw_pkg::STACK_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [1:0]  req_match_mode,
   input  logic [15:0] req_dev_id,
   input  logic [12:0] req_dev_width,
   input  logic [12:0] req_dev_height,
   input  logic [2:0]  req_dev_kind,
   input  logic [9:0]  req_refresh_rate,
   input  logic [7:0]  req_loudness,
   input  logic        req_sound_boost,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_match_count,
   output logic        rsp_found,
   output logic [6:0]  rsp_position,
   output logic [15:0] rsp_top_id,
   output logic [12:0] rsp_top_width,
   output logic [12:0] rsp_top_height,
   output logic [2:0]  rsp_top_kind,
   output logic [9:0]  rsp_top_rate,
   output logic [7:0]  rsp_top_loudness,
   output logic        rsp_top_sound_boost
);
   import rsw_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type dp_status;

   rsw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .dp_status (dp_status),
      .cmd       (cmd)
   );

   rsw_dp #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .dp_status           (dp_status),
      .req_action          (req_action),
      .req_match_mode      (req_match_mode),
      .req_dev_id          (req_dev_id),
      .req_dev_width       (req_dev_width),
      .req_dev_height      (req_dev_height),
      .req_dev_kind        (req_dev_kind),
      .req_refresh_rate    (req_refresh_rate),
      .req_loudness        (req_loudness),
      .req_sound_boost     (req_sound_boost),
      .rsp_status          (rsp_status),
      .rsp_match_count     (rsp_match_count),
      .rsp_found           (rsp_found),
      .rsp_position        (rsp_position),
      .rsp_top_id          (rsp_top_id),
      .rsp_top_width       (rsp_top_width),
      .rsp_top_height      (rsp_top_height),
      .rsp_top_kind        (rsp_top_kind),
      .rsp_top_rate        (rsp_top_rate),
      .rsp_top_loudness    (rsp_top_loudness),
      .rsp_top_sound_boost (rsp_top_sound_boost)
   );

endmodule

@@ bench/tb_record_stack_with_search.sv @@
// Self-checking testbench for the record stack with search, with a shadow stack predictor.
module tb_record_stack_with_search;
   timeunit 1ns;
   timeprecision 1ps;

   import rsw_pkg::*;

   localparam int DEPTH = STACK_DEPTH_DEF;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int LONG_HOLD = 400;
   localparam int RANDOM_PER_PHASE = 400;
   localparam int SETTLE_CYCLES = 80;
   localparam logic [2:0] ACT_SPARE_LO = 3'd6;
   localparam logic [2:0] ACT_SPARE_HI = 3'd7;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   typedef struct packed {
      logic [2:0] action;
      logic [1:0] mode;
      rec_type    rec;
   } stack_cmd_type;

   typedef struct packed {
      logic [1:0] status;
      logic [6:0] match_count;
      logic       found;
      logic [6:0] position;
      rec_type    top;
   } stack_reply_type;

   typedef struct {
      stack_cmd_type   cmd;
      bit              typed;
      stack_reply_type want;
   } directed_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_action = '0;
   logic [1:0]  req_match_mode = '0;
   logic [15:0] req_dev_id = '0;
   logic [12:0] req_dev_width = '0;
   logic [12:0] req_dev_height = '0;
   logic [2:0]  req_dev_kind = '0;
   logic [9:0]  req_refresh_rate = '0;
   logic [7:0]  req_loudness = '0;
   logic        req_sound_boost = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_match_count;
   logic        rsp_found;
   logic [6:0]  rsp_position;
   logic [15:0] rsp_top_id;
   logic [12:0] rsp_top_width;
   logic [12:0] rsp_top_height;
   logic [2:0]  rsp_top_kind;
   logic [9:0]  rsp_top_rate;
   logic [7:0]  rsp_top_loudness;
   logic        rsp_top_sound_boost;

   rec_type          shadow_store [DEPTH];
   int               shadow_fill = 0;
   bit               filling = 1'b1;
   stack_reply_type  awaited_replies [$];
   directed_row_type directed_rows [$];
   int               mismatches = 0;
   int               cycle_count = 0;
   int               send_idle_pct = 0;
   int               stall_pct = 0;
   int               hold_requests = 0;
   int               hold_served = 0;
   int               hold_left = 0;
   int               fill_cuts [6] = '{55, 62, 70, 82, 96, 96};
   int               drain_cuts [6] = '{8, 60, 68, 80, 94, 97};

   record_stack_with_search dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_match_mode      (req_match_mode),
      .req_dev_id          (req_dev_id),
      .req_dev_width       (req_dev_width),
      .req_dev_height      (req_dev_height),
      .req_dev_kind        (req_dev_kind),
      .req_refresh_rate    (req_refresh_rate),
      .req_loudness        (req_loudness),
      .req_sound_boost     (req_sound_boost),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_match_count     (rsp_match_count),
      .rsp_found           (rsp_found),
      .rsp_position        (rsp_position),
      .rsp_top_id          (rsp_top_id),
      .rsp_top_width       (rsp_top_width),
      .rsp_top_height      (rsp_top_height),
      .rsp_top_kind        (rsp_top_kind),
      .rsp_top_rate        (rsp_top_rate),
      .rsp_top_loudness    (rsp_top_loudness),
      .rsp_top_sound_boost (rsp_top_sound_boost)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic rec_type mk_rec(logic [15:0] id, logic [12:0] width, logic [12:0] height,
                                      logic [2:0] kind, logic [9:0] rate, logic [7:0] loudness,
                                      logic sound_boost);
      rec_type r;
      r.id = id;
      r.width = width;
      r.height = height;
      r.kind = kind;
      r.rate = rate;
      r.loudness = loudness;
      r.sound_boost = sound_boost;
      return r;
   endfunction

   function automatic stack_reply_type mk_reply(logic [1:0] status, logic [6:0] match_count,
                                                logic found, logic [6:0] position,
                                                rec_type top);
      stack_reply_type r;
      r.status = status;
      r.match_count = match_count;
      r.found = found;
      r.position = position;
      r.top = top;
      return r;
   endfunction

   function automatic bit key_hit(rec_type entry, logic [1:0] mode, rec_type key);
      case (mode)
         MODE_ID:   return entry.id == key.id;
         MODE_KIND: return entry.kind == key.kind;
         MODE_RES:  return (entry.width == key.width) && (entry.height == key.height);
         default:   return 1'b0;
      endcase
   endfunction

   // Applies one command to the shadow stack and returns the reply it should produce.
   function automatic stack_reply_type apply_to_shadow(stack_cmd_type cmd);
      stack_reply_type r;
      int hits;
      r = '0;
      hits = 0;
      case (cmd.action)
         ACT_PUSH: begin
            if (shadow_fill >= DEPTH) begin
               r.status = STS_FULL;
            end else begin
               shadow_store[shadow_fill] = cmd.rec;
               shadow_fill++;
            end
         end
         ACT_POP: begin
            if (shadow_fill == 0) r.status = STS_EMPTY;
            else shadow_fill--;
         end
         ACT_PEEK: begin
            if (shadow_fill == 0) r.status = STS_EMPTY;
            else r.top = shadow_store[shadow_fill - 1];
         end
         ACT_COUNT: begin
            if (shadow_fill == 0) begin
               r.status = STS_EMPTY;
            end else begin
               for (int i = 0; i < shadow_fill; i++)
                  if (key_hit(shadow_store[i], cmd.mode, cmd.rec)) hits++;
               r.match_count = 7'(hits);
            end
         end
         ACT_FIND: begin
            if (shadow_fill == 0) begin
               r.status = STS_EMPTY;
            end else begin
               // Positions count from the top of the stack, starting at one.
               for (int i = shadow_fill - 1; i >= 0; i--) begin
                  if (!r.found && key_hit(shadow_store[i], cmd.mode, cmd.rec)) begin
                     r.found = 1'b1;
                     r.position = 7'(shadow_fill - i);
                  end
               end
            end
         end
         ACT_CLEAR: begin
            shadow_fill = 0;
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // Most beats follow the fill direction so that the stack sweeps between empty and full.
   function automatic stack_cmd_type random_beat();
      stack_cmd_type c;
      rec_type donor;
      int pick;
      int cut [6];
      c.rec = mk_rec(16'($urandom), 13'($urandom), 13'($urandom), 3'($urandom),
                     10'($urandom), 8'($urandom), 1'($urandom));
      c.mode = ($urandom_range(19) == 0) ? MODE_SPARE : 2'($urandom_range(2));
      if (shadow_fill >= DEPTH) filling = 1'b0;
      else if (shadow_fill == 0) filling = 1'b1;
      if (filling) cut = fill_cuts;
      else cut = drain_cuts;
      pick = $urandom_range(99);
      if (pick < cut[0]) c.action = ACT_PUSH;
      else if (pick < cut[1]) c.action = ACT_POP;
      else if (pick < cut[2]) c.action = ACT_PEEK;
      else if (pick < cut[3]) c.action = ACT_COUNT;
      else if (pick < cut[4]) c.action = ACT_FIND;
      else if (pick < cut[5]) c.action = ACT_CLEAR;
      else c.action = $urandom_range(1) ? ACT_SPARE_HI : ACT_SPARE_LO;
      if (shadow_fill > 0) begin
         donor = shadow_store[$urandom_range(shadow_fill - 1)];
         if (c.action == ACT_PUSH) begin
            if ($urandom_range(9) < 3) c.rec.id = donor.id;
            if ($urandom_range(9) < 3) begin
               c.rec.width = donor.width;
               c.rec.height = donor.height;
            end
         end else if ($urandom_range(9) < 7) begin
            c.rec.id = donor.id;
            c.rec.kind = donor.kind;
            c.rec.width = donor.width;
            c.rec.height = donor.height;
         end
      end
      return c;
   endfunction

   task automatic add_row(logic [2:0] action, logic [1:0] mode, rec_type rec, bit typed,
                          stack_reply_type want);
      directed_row_type row;
      row.cmd.action = action;
      row.cmd.mode = mode;
      row.cmd.rec = rec;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endtask

   // Offers one beat, holding it steady until accepted, then records what should come back.
   task automatic send_beat(stack_cmd_type cmd, bit typed, stack_reply_type want);
      stack_reply_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= cmd.action;
      req_match_mode <= cmd.mode;
      req_dev_id <= cmd.rec.id;
      req_dev_width <= cmd.rec.width;
      req_dev_height <= cmd.rec.height;
      req_dev_kind <= cmd.rec.kind;
      req_refresh_rate <= cmd.rec.rate;
      req_loudness <= cmd.rec.loudness;
      req_sound_boost <= cmd.rec.sound_boost;
      do @(posedge clock); while (!req_ready);
      predicted = apply_to_shadow(cmd);
      awaited_replies.push_back(typed ? want : predicted);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (awaited_replies.size() != 0) @(posedge clock);
   endtask

   function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      stack_reply_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_replies.size() == 0) begin
            $display("%0t ns: reply beat with none awaited, status %0d", $time, rsp_status);
            mismatches++;
         end else begin
            want = awaited_replies.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("match_count", want.match_count, rsp_match_count);
            check_field("found", want.found, rsp_found);
            check_field("position", want.position, rsp_position);
            check_field("top_id", want.top.id, rsp_top_id);
            check_field("top_width", want.top.width, rsp_top_width);
            check_field("top_height", want.top.height, rsp_top_height);
            check_field("top_kind", want.top.kind, rsp_top_kind);
            check_field("top_rate", want.top.rate, rsp_top_rate);
            check_field("top_loudness", want.top.loudness, rsp_top_loudness);
            check_field("top_sound_boost", want.top.sound_boost, rsp_top_sound_boost);
         end
      end
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_record_stack_with_search: FAIL");
         $finish;
      end
   end

   initial begin
      rec_type ones;
      rec_type nil;
      rec_type big_tv;
      stack_reply_type none;
      int phase;
      int n;
      int send_pcts [4];
      int stall_pcts [4];
      ones = '1;
      nil = '0;
      none = '0;
      big_tv = mk_rec(16'h1234, 13'd1920, 13'd1080, 3'd4, 10'd120, 8'd95, 1'b1);
      send_pcts = '{0, 49, 0, 21};
      stall_pcts = '{0, 0, 49, 21};

      add_row(ACT_POP, MODE_ID, nil, 1'b1, mk_reply(STS_EMPTY, 7'd0, 1'b0, 7'd0, nil));
      add_row(ACT_PEEK, MODE_ID, nil, 1'b1, mk_reply(STS_EMPTY, 7'd0, 1'b0, 7'd0, nil));
      add_row(ACT_COUNT, MODE_KIND, nil, 1'b1, mk_reply(STS_EMPTY, 7'd0, 1'b0, 7'd0, nil));
      add_row(ACT_FIND, MODE_RES, nil, 1'b1, mk_reply(STS_EMPTY, 7'd0, 1'b0, 7'd0, nil));
      add_row(ACT_SPARE_LO, MODE_ID, ones, 1'b1, none);
      add_row(ACT_PUSH, MODE_ID, ones, 1'b1, none);
      add_row(ACT_PEEK, MODE_ID, nil, 1'b1, mk_reply(STS_OK, 7'd0, 1'b0, 7'd0, ones));
      add_row(ACT_PUSH, MODE_ID, nil, 1'b1, none);
      add_row(ACT_PEEK, MODE_ID, ones, 1'b1, none);
      add_row(ACT_COUNT, MODE_ID, nil, 1'b1, mk_reply(STS_OK, 7'd1, 1'b0, 7'd0, nil));
      add_row(ACT_COUNT, MODE_KIND, ones, 1'b1, mk_reply(STS_OK, 7'd1, 1'b0, 7'd0, nil));
      add_row(ACT_COUNT, MODE_RES, ones, 1'b1, mk_reply(STS_OK, 7'd1, 1'b0, 7'd0, nil));
      add_row(ACT_COUNT, MODE_SPARE, nil, 1'b1, none);
      add_row(ACT_FIND, MODE_ID, ones, 1'b1, mk_reply(STS_OK, 7'd0, 1'b1, 7'd2, nil));
      add_row(ACT_FIND, MODE_RES, nil, 1'b1, mk_reply(STS_OK, 7'd0, 1'b1, 7'd1, nil));
      add_row(ACT_FIND, MODE_SPARE, nil, 1'b1, none);
      add_row(ACT_FIND, MODE_ID, big_tv, 1'b1, none);
      add_row(ACT_PUSH, MODE_ID, big_tv, 1'b0, none);
      add_row(ACT_FIND, MODE_KIND, big_tv, 1'b0, none);
      add_row(ACT_COUNT, MODE_RES, mk_rec(16'h0042, 13'd1920, 13'd1080, 3'd1, 10'd60, 8'd0, 1'b0),
              1'b0, none);
      add_row(ACT_SPARE_HI, MODE_SPARE, ones, 1'b1, none);
      add_row(ACT_POP, MODE_ID, nil, 1'b1, none);
      add_row(ACT_POP, MODE_ID, nil, 1'b1, none);
      add_row(ACT_CLEAR, MODE_ID, nil, 1'b1, none);
      add_row(ACT_PEEK, MODE_ID, nil, 1'b1, mk_reply(STS_EMPTY, 7'd0, 1'b0, 7'd0, nil));

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_beat(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
      wait_drained();

      for (phase = 0; phase < 4; phase++) begin
         send_idle_pct = send_pcts[phase];
         stall_pct = stall_pcts[phase];
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            // A long receiver hold-off backs the block up while beats keep being offered.
            if (phase == 0 && n == 100) hold_requests <= hold_requests + 1;
            if (phase == 0 && n == 250) wait_drained();
            send_beat(random_beat(), 1'b0, none);
         end
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_record_stack_with_search: PASS");
      end else begin
         $display("tb_record_stack_with_search: FAIL");
      end
      $finish;
   end

endmodule
